FILE: rtl/stepping_substitution_cipher_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stepping substitution cipher
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef STEPPING_SUBSTITUTION_CIPHER_ASSERT_SVH
`define STEPPING_SUBSTITUTION_CIPHER_ASSERT_SVH

// Property checked outside reset.
`define SSC_ASSERT_RUN(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ssc assertion failed");

// Property that also covers the reset cycles.
`define SSC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ssc reset assertion failed");

`endif

FILE: rtl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Types and constants shared by the stepping substitution cipher modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

    localparam int unsigned ALPHA_LEN  = 26;
    localparam int unsigned KEY_W      = 5;
    localparam int unsigned CFG_DATA_W = 60;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [7:0] LOWER_BASE = 8'h61;
    localparam logic [7:0] UPPER_BASE = 8'h41;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd2;

    typedef logic [ALPHA_LEN-1:0][KEY_W-1:0] key_array_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       mode;
        logic       in_last;
    } ssc_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } ssc_out_t;

endpackage

`default_nettype wire

FILE: rtl/ssc_key_regs.sv
// ----------------------------------------------------------------------------
// ssc_key_regs
// Holds the 26-entry substitution key written through the register port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssc_key_regs (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [ssc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [ssc_pkg::CFG_DATA_W-1:0]       cfg_data,
    output ssc_pkg::key_array_t                       keys
);

    logic [59:0] key_low_reg;
    logic [59:0] key_mid_reg;
    logic [9:0]  key_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_mid_reg  <= '0;
            key_high_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ssc_pkg::CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                ssc_pkg::CFG_KEY_MID:  key_mid_reg  <= cfg_data;
                ssc_pkg::CFG_KEY_HIGH: key_high_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    assign keys = {key_high_reg, key_mid_reg, key_low_reg};

endmodule

`default_nettype wire

FILE: rtl/ssc_xform.sv
// ----------------------------------------------------------------------------
// ssc_xform
// Maps one registered character through the key in encode or decode mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssc_xform (
    input  wire ssc_pkg::ssc_in_t     item,
    input  wire logic [4:0]           wheel_sum,
    input  wire ssc_pkg::key_array_t  keys,
    output ssc_pkg::ssc_out_t         result
);

    logic       is_lower;
    logic       is_upper;
    logic [7:0] base;
    logic [7:0] offset;
    logic [4:0] pos;
    logic [5:0] enc_raw;
    logic [4:0] enc_idx;
    logic [4:0] enc_val;
    logic [4:0] match_idx;
    logic [5:0] dec_raw;
    logic [4:0] dec_val;
    logic [4:0] val;

    always_comb begin
        is_lower = (item.in_byte >= ssc_pkg::LOWER_BASE) &&
                   (item.in_byte < ssc_pkg::LOWER_BASE + 8'(ssc_pkg::ALPHA_LEN));
        is_upper = (item.in_byte >= ssc_pkg::UPPER_BASE) &&
                   (item.in_byte < ssc_pkg::UPPER_BASE + 8'(ssc_pkg::ALPHA_LEN));
        base     = is_upper ? ssc_pkg::UPPER_BASE : ssc_pkg::LOWER_BASE;
        offset   = item.in_byte - base;
        pos      = offset[4:0];

        enc_raw = {1'b0, pos} + {1'b0, wheel_sum};
        if (enc_raw >= 6'(ssc_pkg::ALPHA_LEN)) begin
            enc_raw = enc_raw - 6'(ssc_pkg::ALPHA_LEN);
        end
        enc_idx = enc_raw[4:0];
        enc_val = keys[enc_idx];

        match_idx = 5'(ssc_pkg::ALPHA_LEN);
        for (int k = ssc_pkg::ALPHA_LEN - 1; k >= 0; k--) begin
            if (keys[k] == pos) begin
                match_idx = 5'(k);
            end
        end

        dec_raw = {1'b0, match_idx} + 6'(ssc_pkg::ALPHA_LEN) - {1'b0, wheel_sum};
        if (dec_raw >= 6'(2 * ssc_pkg::ALPHA_LEN)) begin
            dec_raw = dec_raw - 6'(2 * ssc_pkg::ALPHA_LEN);
        end else if (dec_raw >= 6'(ssc_pkg::ALPHA_LEN)) begin
            dec_raw = dec_raw - 6'(ssc_pkg::ALPHA_LEN);
        end
        dec_val = dec_raw[4:0];

        val = item.mode ? dec_val : enc_val;

        result.out_last = item.in_last;
        if (is_lower || is_upper) begin
            result.out_byte = base + {3'b000, val};
        end else begin
            result.out_byte = item.in_byte;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/stepping_substitution_cipher.sv
// ----------------------------------------------------------------------------
// stepping_substitution_cipher
// One character per cycle while the output is not stalled, through a key whose offset steps like an odometer.
// ----------------------------------------------------------------------------
// Each transfer on the s_ channel carries one character, a mode bit and a last
// flag; exactly one result follows on the m_ channel via the input and result
// registers, and a new character can be taken in every cycle unless the output
// stalls. The character enters the input register with the wheel sum mod 26,
// is mapped by a single combinational pass (key lookup for encode, priority
// compare over all 26 key entries for decode), and lands in the result
// register. The wheels step on every accepted character and clear after one
// marked last. The user must write key registers via cfg_wr_en, cfg_index and
// cfg_data only when the stream is idle (not enforced); index 3 is ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stepping_substitution_cipher (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [ssc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ssc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire ssc_pkg::ssc_in_t                 s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output ssc_pkg::ssc_out_t                     m_data
);

    ssc_pkg::key_array_t keys;
    ssc_pkg::ssc_in_t    in_item_reg;
    ssc_pkg::ssc_out_t   result;
    ssc_pkg::ssc_out_t   m_data_reg;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [4:0] wheel_sum_reg;
    logic [4:0] wheel_sum_next;
    logic [5:0] wheel_sum_raw;
    logic [4:0] fast_wheel_reg;
    logic [4:0] fast_wheel_next;
    logic [4:0] slow_wheel_reg;
    logic [4:0] slow_wheel_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       s_xfer;
    logic       out_load;

    ssc_key_regs u_key_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .keys      (keys)
    );

    ssc_xform u_xform (
        .item      (in_item_reg),
        .wheel_sum (wheel_sum_reg),
        .keys      (keys),
        .result    (result)
    );

    assign out_load = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;
    assign s_xfer   = s_valid && s_ready;

    always_comb begin
        wheel_sum_raw = {1'b0, fast_wheel_reg} + {1'b0, slow_wheel_reg};
        if (wheel_sum_raw >= 6'(ssc_pkg::ALPHA_LEN)) begin
            wheel_sum_raw = wheel_sum_raw - 6'(ssc_pkg::ALPHA_LEN);
        end
        wheel_sum_next = wheel_sum_raw[4:0];

        fast_wheel_next = fast_wheel_reg;
        slow_wheel_next = slow_wheel_reg;
        if (s_xfer) begin
            if (s_data.in_last) begin
                fast_wheel_next = '0;
                slow_wheel_next = '0;
            end else if (fast_wheel_reg == 5'(ssc_pkg::ALPHA_LEN - 1)) begin
                fast_wheel_next = '0;
                if (slow_wheel_reg == 5'(ssc_pkg::ALPHA_LEN - 1)) begin
                    slow_wheel_next = '0;
                end else begin
                    slow_wheel_next = slow_wheel_reg + 5'd1;
                end
            end else begin
                fast_wheel_next = fast_wheel_reg + 5'd1;
            end
        end

        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_wheel_reg <= '0;
            slow_wheel_reg <= '0;
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            fast_wheel_reg <= fast_wheel_next;
            slow_wheel_reg <= slow_wheel_next;
            in_valid_reg   <= in_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg   <= s_data;
            wheel_sum_reg <= wheel_sum_next;
        end
        if (out_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: rtl/ssc_checker.sv
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks on the stepping substitution cipher handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "stepping_substitution_cipher_assert.svh"

module ssc_checker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [ssc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ssc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             s_valid,
    input  wire logic                             s_ready,
    input  wire ssc_pkg::ssc_in_t                 s_data,
    input  wire logic                             m_valid,
    input  wire logic                             m_ready,
    input  wire ssc_pkg::ssc_out_t                m_data
);

    logic cfg_seen;
    logic s_seen;

    assign cfg_seen = cfg_wr_en && (cfg_index == ssc_pkg::CFG_KEY_LOW) && (cfg_data != '0);
    assign s_seen   = s_valid && (s_data.in_byte != '0);

    // A stalled result transfer keeps its payload.
    `SSC_ASSERT_RUN(a_m_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // The result channel is empty right after reset.
    `SSC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

    // Input only stalls when a result is waiting.
    `SSC_ASSERT_RUN(a_stall_full, aclk, aresetn, !s_ready |-> m_valid)

    // With both stages full after a stalled transfer, input follows output.
    `SSC_ASSERT_RUN(a_full_follow, aclk, aresetn, m_valid && !m_ready && s_valid && s_ready |=> s_ready == m_ready)

    // Writes to the key port never disturb a waiting result.
    `SSC_ASSERT_RUN(a_cfg_quiet, aclk, aresetn, cfg_seen && !s_seen && m_valid && !m_ready |=> m_valid)

endmodule

bind stepping_substitution_cipher ssc_checker u_ssc_checker (.*);

`default_nettype wire
